FILE: rtl/core/event_trace_ring_log_defines.svh
// Assertion macros for the trace ring log.
// Used by event_trace_ring_log; expects clk and arst_n in scope.
`ifndef EVENT_TRACE_RING_LOG_DEFINES_SVH
`define EVENT_TRACE_RING_LOG_DEFINES_SVH

// same-cycle implication
`define ETRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/etrl_pkg.sv
// Types and codes for the trace ring log.
// No dependencies; imported by every module of the block.
package etrl_pkg;

	localparam logic [2:0] CMD_TIMER    = 3'd0;
	localparam logic [2:0] CMD_UART     = 3'd1;
	localparam logic [2:0] CMD_DISK     = 3'd2;
	localparam logic [2:0] CMD_WRITE    = 3'd3;
	localparam logic [2:0] CMD_TRUNCATE = 3'd4;
	localparam logic [2:0] CMD_CREATE   = 3'd5;
	localparam logic [2:0] CMD_UNLINK   = 3'd6;
	localparam logic [2:0] CMD_READ     = 3'd7;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [31:0]        tick_stamp;
		logic signed [31:0] proc_id;
		logic               inode_present;
		logic [15:0]        inode_number;
		logic [31:0]        file_offset;
		logic signed [31:0] byte_count;
		logic               append_flag;
		logic signed [31:0] read_limit;
	} evt_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [31:0]        entry_tick;
		logic signed [31:0] entry_proc;
		logic [15:0]        entry_inode;
		logic [31:0]        entry_offset;
		logic [30:0]        entry_bytes;
		logic               entry_append;
		logic               last_of_run;
		logic [31:0]        timer_total;
		logic [31:0]        uart_total;
		logic [31:0]        disk_total;
	} rsp_t;

	typedef struct packed {
		logic [31:0]        tick;
		logic signed [31:0] proc_id;
		logic [15:0]        inode;
		logic [31:0]        offset;
		logic [30:0]        bytes;
		logic               append;
	} entry_t;

endpackage

FILE: rtl/core/etrl_mem.sv
// Log entry store: one write port, one read port, registered read data.
// Depends on etrl_pkg for the entry type.
module etrl_mem import etrl_pkg::*; #(
	parameter int LOG_DEPTH = 16,
	localparam int PW = $clog2(LOG_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [PW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [PW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [LOG_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/etrl_ctrl.sv
// Sequencer: pointers, fill level, interrupt counters and the drain loop.
// Depends on etrl_pkg; drives the ports of etrl_mem.
module etrl_ctrl import etrl_pkg::*; #(
	parameter int LOG_DEPTH = 16,
	localparam int PW = $clog2(LOG_DEPTH),
	localparam int FW = $clog2(LOG_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  evt_t          evt,
	input  logic          out_free,
	output logic          busy,
	output logic          ld,
	output rsp_t          rsp_d,
	output logic          wr_en,
	output logic [PW-1:0] wr_addr,
	output entry_t        wr_data,
	output logic          rd_en,
	output logic [PW-1:0] rd_addr,
	input  entry_t        rd_data
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic          state_q, state_d;
	logic [PW-1:0] wr_ptr_q, wr_ptr_d;
	logic [PW-1:0] rd_ptr_q, rd_ptr_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [FW-1:0] remain_q, remain_d;
	logic [31:0]   timer_q, timer_d;
	logic [31:0]   uart_q, uart_d;
	logic [31:0]   disk_q, disk_d;
	logic [FW-1:0] lim;
	logic [FW-1:0] take;
	logic          is_write;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(LOG_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		if (evt.read_limit[31]) begin
			lim = '0;
		end else if (evt.read_limit[30:0] >= 31'(LOG_DEPTH)) begin
			lim = FW'(LOG_DEPTH);
		end else begin
			lim = evt.read_limit[FW-1:0];
		end
		take = (lim < fill_q) ? lim : fill_q;
	end

	assign is_write = (evt.cmd == CMD_WRITE);

	always_comb begin
		wr_data.tick    = evt.tick_stamp;
		wr_data.proc_id = evt.proc_id;
		wr_data.inode   = evt.inode_number;
		wr_data.offset  = is_write ? evt.file_offset : 32'd0;
		wr_data.bytes   = (is_write && !evt.byte_count[31]) ? evt.byte_count[30:0] : 31'd0;
		wr_data.append  = is_write & evt.append_flag;
	end

	assign wr_addr = wr_ptr_q;
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		fill_d   = fill_q;
		remain_d = remain_q;
		timer_d  = timer_q;
		uart_d   = uart_q;
		disk_d   = disk_q;
		ld       = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = rd_ptr_q;
		rsp_d    = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ld = 1'b1;
					rsp_d.result_kind = KIND_ACK;
					rsp_d.last_of_run = 1'b1;
					case (evt.cmd)
						CMD_TIMER: timer_d = timer_q + 32'd1;
						CMD_UART:  uart_d  = uart_q + 32'd1;
						CMD_DISK:  disk_d  = disk_q + 32'd1;
						CMD_WRITE, CMD_TRUNCATE, CMD_CREATE, CMD_UNLINK: begin
							if (evt.inode_present) begin
								wr_en    = 1'b1;
								wr_ptr_d = ptr_inc(wr_ptr_q);
								if (fill_q < FW'(LOG_DEPTH)) begin
									fill_d = fill_q + 1'b1;
								end else begin
									rd_ptr_d = ptr_inc(rd_ptr_q);
								end
							end
						end
						CMD_READ: begin
							if (take == '0) begin
								rsp_d.result_kind = KIND_EMPTY;
							end else begin
								ld       = 1'b0;
								rd_en    = 1'b1;
								remain_d = take;
								state_d  = ST_DRAIN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				// read data for rd_ptr_q is in rd_data; next read issued as it leaves
				if (out_free) begin
					ld = 1'b1;
					rsp_d.result_kind  = KIND_ENTRY;
					rsp_d.entry_tick   = rd_data.tick;
					rsp_d.entry_proc   = rd_data.proc_id;
					rsp_d.entry_inode  = rd_data.inode;
					rsp_d.entry_offset = rd_data.offset;
					rsp_d.entry_bytes  = rd_data.bytes;
					rsp_d.entry_append = rd_data.append;
					rsp_d.last_of_run  = (remain_q == FW'(1));
					rd_ptr_d = ptr_inc(rd_ptr_q);
					fill_d   = fill_q - 1'b1;
					remain_d = remain_q - 1'b1;
					if (remain_q == FW'(1)) begin
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = ptr_inc(rd_ptr_q);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		rsp_d.timer_total = timer_d;
		rsp_d.uart_total  = uart_d;
		rsp_d.disk_total  = disk_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			remain_q <= '0;
			timer_q  <= '0;
			uart_q   <= '0;
			disk_q   <= '0;
		end else begin
			state_q  <= state_d;
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
			timer_q  <= timer_d;
			uart_q   <= uart_d;
			disk_q   <= disk_d;
		end
	end

endmodule

FILE: rtl/core/event_trace_ring_log.sv
// Trace ring log top level: event channel in, result channel out.
// Depends on etrl_pkg, etrl_ctrl, etrl_mem and event_trace_ring_log_defines.svh.
//
// Usage: one event word on evt per handshake (evt_valid high, evt_stall low).
// Interrupt, write, truncate, create and unlink words give one acknowledge
// word on rsp in the cycle after acceptance; they are taken one per cycle
// while the result side keeps up.
// A read word drains min(limit, LOG_DEPTH, fill) entries oldest first: the
// first entry word passes the read register of the entry store and then the
// output register, and later words follow one per cycle while the result
// side keeps up. last_of_run marks the final word of a run. A read with
// nothing to drain gives one empty word. No new event is taken until a drain
// finishes. Results leave through an output register; while rsp_stall is high
// the word there holds and evt_stall is high with it.
// Reset (arst_n low) clears pointers, fill level and the three counters;
// the entry store itself is not cleared, and unwritten entries are never read.
`include "event_trace_ring_log_defines.svh"

module event_trace_ring_log import etrl_pkg::*; #(
	parameter int LOG_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  evt_t evt,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int PW = $clog2(LOG_DEPTH);

	logic          accept;
	logic          out_free;
	logic          busy;
	logic          ld;
	rsp_t          rsp_d;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	entry_t        rd_data;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign evt_stall = busy || !out_free;
	assign accept    = evt_valid && !evt_stall;

	etrl_ctrl #(.LOG_DEPTH(LOG_DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.evt      (evt),
		.out_free (out_free),
		.busy     (busy),
		.ld       (ld),
		.rsp_d    (rsp_d),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	etrl_mem #(.LOG_DEPTH(LOG_DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ld) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ETRL_ASSERT_NOW(a_no_load_over_held, rsp_valid && rsp_stall, !ld, "result word overwritten while stalled")
	`ETRL_ASSERT_NEXT(a_ack_follows, accept && evt.cmd != CMD_READ, rsp_valid && rsp.last_of_run, "no single result after non-read word")
	`ETRL_ASSERT_NEXT(a_drain_ends, ld && rsp_d.result_kind == KIND_ENTRY && rsp_d.last_of_run, !busy, "drain still running after last entry")

endmodule

FILE: dv/event_trace_ring_log_test.sv
// Self-checking testbench for event_trace_ring_log.
// A scoreboard class predicts each result word; random and directed event words,
// with idling on both sides. Depends only on etrl_pkg and the RTL.
module event_trace_ring_log_test;
	import etrl_pkg::*;

	localparam int RING_DEPTH = 16;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_TAIL = 8;

	class trace_ring_scoreboard;
		entry_t ring [RING_DEPTH];
		int head;
		int tail;
		int fill;
		logic [31:0] timer_cnt;
		logic [31:0] uart_cnt;
		logic [31:0] disk_cnt;
		rsp_t awaited [$];
		int errors;

		function new();
			head = 0;
			tail = 0;
			fill = 0;
			timer_cnt = '0;
			uart_cnt = '0;
			disk_cnt = '0;
			errors = 0;
		endfunction

		function void await_word(logic [1:0] kind, entry_t ent, logic last);
			rsp_t r;
			r.result_kind = kind;
			r.entry_tick = ent.tick;
			r.entry_proc = ent.proc_id;
			r.entry_inode = ent.inode;
			r.entry_offset = ent.offset;
			r.entry_bytes = ent.bytes;
			r.entry_append = ent.append;
			r.last_of_run = last;
			r.timer_total = timer_cnt;
			r.uart_total = uart_cnt;
			r.disk_total = disk_cnt;
			awaited.push_back(r);
		endfunction

		function void record_event(evt_t e);
			int n;
			int k;
			entry_t ent;
			if (e.cmd == CMD_READ) begin
				if (e.read_limit[31])
					n = 0;
				else if (e.read_limit > RING_DEPTH)
					n = RING_DEPTH;
				else
					n = int'(e.read_limit);
				k = 0;
				while (k < n && fill > 0) begin
					await_word(KIND_ENTRY, ring[head], (k + 1 == n) || (fill == 1));
					head = (head + 1) % RING_DEPTH;
					fill--;
					k++;
				end
				if (k == 0)
					await_word(KIND_EMPTY, '0, 1'b1);
				return;
			end
			case (e.cmd)
				CMD_TIMER: timer_cnt += 1;
				CMD_UART: uart_cnt += 1;
				CMD_DISK: disk_cnt += 1;
				default: begin
					if (e.inode_present) begin
						ent = '0;
						ent.tick = e.tick_stamp;
						ent.proc_id = e.proc_id;
						ent.inode = e.inode_number;
						if (e.cmd == CMD_WRITE) begin
							ent.offset = e.file_offset;
							ent.bytes = e.byte_count[31] ? '0 : e.byte_count[30:0];
							ent.append = e.append_flag;
						end
						ring[tail] = ent;
						tail = (tail + 1) % RING_DEPTH;
						// full ring: oldest entry is lost
						if (fill < RING_DEPTH)
							fill++;
						else
							head = (head + 1) % RING_DEPTH;
					end
				end
			endcase
			await_word(KIND_ACK, '0, 1'b1);
		endfunction

		function void check_field(string tag, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t %s expected %h actual %h", $time, tag, want, got);
				errors++;
			end
		endfunction

		function void match_result(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$display("%0t unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
			check_field("entry_tick", want.entry_tick, got.entry_tick);
			check_field("entry_proc", want.entry_proc, got.entry_proc);
			check_field("entry_inode", 32'(want.entry_inode), 32'(got.entry_inode));
			check_field("entry_offset", want.entry_offset, got.entry_offset);
			check_field("entry_bytes", 32'(want.entry_bytes), 32'(got.entry_bytes));
			check_field("entry_append", 32'(want.entry_append), 32'(got.entry_append));
			check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
			check_field("timer_total", want.timer_total, got.timer_total);
			check_field("uart_total", want.uart_total, got.uart_total);
			check_field("disk_total", want.disk_total, got.disk_total);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic evt_valid;
	logic evt_stall;
	evt_t evt;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	trace_ring_scoreboard board;
	int send_idle = 32;
	int recv_idle = 46;
	int quiet = 0;

	event_trace_ring_log #(.LOG_DEPTH(RING_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			board.match_result(rsp);
		if (evt_valid && !evt_stall)
			board.record_event(evt);
		if ((rsp_valid && !rsp_stall) || (evt_valid && !evt_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic drive_word(input evt_t w);
		while ($urandom_range(99) < send_idle) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= w;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic evt_t plain_event(logic [2:0] c);
		evt_t e;
		e = '0;
		e.cmd = c;
		e.inode_present = 1'b1;
		e.tick_stamp = $urandom;
		e.inode_number = 16'($urandom);
		return e;
	endfunction

	function automatic evt_t random_event();
		evt_t e;
		int pick;
		pick = $urandom_range(99);
		if (pick < 9)
			e.cmd = CMD_READ;
		else if (pick < 14)
			e.cmd = CMD_TIMER;
		else if (pick < 18)
			e.cmd = CMD_UART;
		else if (pick < 22)
			e.cmd = CMD_DISK;
		else if (pick < 60)
			e.cmd = CMD_WRITE;
		else if (pick < 73)
			e.cmd = CMD_TRUNCATE;
		else if (pick < 86)
			e.cmd = CMD_CREATE;
		else
			e.cmd = CMD_UNLINK;
		e.tick_stamp = edge_word();
		e.proc_id = edge_word();
		if (e.proc_id[31])
			e.proc_id = -1;
		e.inode_present = ($urandom_range(9) != 0);
		e.inode_number = 16'($urandom);
		e.file_offset = edge_word();
		e.byte_count = edge_word();
		e.append_flag = 1'($urandom_range(1));
		case ($urandom_range(19))
			12, 13, 14: e.read_limit = $urandom_range(20, 7);
			15: e.read_limit = 0;
			16: e.read_limit = edge_word() | 32'h8000_0000;
			17: e.read_limit = $urandom;
			18: e.read_limit = RING_DEPTH;
			19: e.read_limit = RING_DEPTH + 1;
			default: e.read_limit = $urandom_range(6, 1);
		endcase
		return e;
	endfunction

	task automatic directed_run();
		evt_t w;
		w = plain_event(CMD_READ);
		w.read_limit = 5;
		drive_word(w);
		drive_word(plain_event(CMD_TIMER));
		drive_word(plain_event(CMD_UART));
		drive_word(plain_event(CMD_DISK));
		w = plain_event(CMD_WRITE);
		w.tick_stamp = '1;
		w.proc_id = -1;
		w.inode_number = '1;
		w.file_offset = '1;
		w.byte_count = 32'h7FFF_FFFF;
		w.append_flag = 1'b1;
		drive_word(w);
		w = plain_event(CMD_WRITE);
		w.tick_stamp = '0;
		w.proc_id = 32'h7FFF_FFFF;
		w.inode_number = '0;
		w.byte_count = 32'h8000_0000;
		drive_word(w);
		w = plain_event(CMD_WRITE);
		w.byte_count = -1;
		w.file_offset = 32'h1234_5678;
		drive_word(w);
		// offset, bytes and append are dropped for non-write events
		w = plain_event(CMD_TRUNCATE);
		w.file_offset = '1;
		w.byte_count = 100;
		w.append_flag = 1'b1;
		drive_word(w);
		w.cmd = CMD_CREATE;
		drive_word(w);
		w.cmd = CMD_UNLINK;
		drive_word(w);
		w = plain_event(CMD_WRITE);
		w.inode_present = 1'b0;
		w.byte_count = 9;
		drive_word(w);
		w.cmd = CMD_UNLINK;
		drive_word(w);
		w = plain_event(CMD_READ);
		w.read_limit = 0;
		drive_word(w);
		w.read_limit = 32'h8000_0000;
		drive_word(w);
		w.read_limit = 2;
		drive_word(w);
		w.read_limit = 32'h7FFF_FFFF;
		drive_word(w);
		w.read_limit = 1;
		drive_word(w);
	endtask

	task automatic random_run(input int s_idle, input int r_idle);
		evt_t w;
		int counted;
		send_idle = s_idle;
		recv_idle = r_idle;
		counted = 0;
		while (counted < 100) begin
			w = random_event();
			drive_word(w);
			if (!(w.cmd >= CMD_WRITE && w.cmd <= CMD_UNLINK && !w.inode_present))
				counted++;
		end
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		evt_valid <= 1'b0;
		evt <= '0;
		rsp_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_run();
		random_run(32, 46);
		random_run(46, 32);
		random_run(0, 0);
		evt_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
